// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, held off during rst.
`define MDBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define MDBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/mdbp_pkg.sv
// Shared types and constants of the median depth back-projector.
// Depends on nothing; imported by every module of the core except mdbp_ram.
package mdbp_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int DEPTH_W = 16;
  localparam int PIX_W = 12;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W = 32;
  localparam int PROD_W = 35;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;

  // One stored sample, depth in the upper bits.
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] column;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

endpackage

// File: rtl/core/median_depth_backprojector_core.sv
// Median depth back-projector, top level: sample RAM, median selector, divider.
// Depends on mdbp_pkg, mdbp_ram, mdbp_select and mdbp_div.
//
// Depth pixels of one region stream in at one word per cycle while loading;
// each pixel whose depth lies within the min/max window is written to the sample
// RAM at the next free slot, and valid pixels beyond MAX_SAMPLES are dropped and
// reported by the overflow flag. The word marked tlast closes the region: input is
// then held off while the median (rank floor(n/2) by depth, earliest arrival on
// ties) is found by 16 radix passes over the RAM plus one pass for ties, each
// through the RAM's single read port. The chosen pixel is then back-projected
// through the pinhole intrinsics with one shared 35-bit restoring divider, and
// the result word is placed in the output register. An empty region skips
// selection and division and yields found = 0 with all coordinates zero. Loading
// of the next region starts as soon as the result word is registered, even while
// it waits to be taken. Configuration must be written by the user through
// cfg_we/cfg_addr/cfg_data only while idle; the block does not enforce it.
module median_depth_backprojector_core #(
  parameter int MAX_SAMPLES = mdbp_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mdbp_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [mdbp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // column [11:0], row [23:12], depth_mm [39:24]
  input  logic [mdbp_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // found [0], median_depth_mm [16:1], median_column [28:17],
  // median_row [40:29], x_mm [72:41], y_mm [104:73], overflow [105], zero [111:106]
  output logic [mdbp_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import mdbp_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_MULX = 3'd2;
  localparam logic [2:0] ST_DIVX = 3'd3;
  localparam logic [2:0] ST_MULY = 3'd4;
  localparam logic [2:0] ST_DIVY = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state;
  logic [CFG_W-1:0] min_depth, max_depth, focal_x, focal_y, center_x, center_y;
  logic [CW-1:0] count;
  logic overflow_seen;
  logic found;
  logic div_wait;

  sample_t in_sample;
  logic in_fire, in_ok, wr_en;

  logic sel_start, sel_done, rd_en;
  logic [AW-1:0] rd_addr;
  logic [SAMPLE_W-1:0] rd_raw;
  sample_t sel_res, pick;

  logic signed [17:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic div_start, div_done;
  logic signed [COORD_W-1:0] div_q, x_mm;

  assign in_sample.column = s_tdata[11:0];
  assign in_sample.row = s_tdata[23:12];
  assign in_sample.depth = s_tdata[39:24];
  assign s_tready = (state == ST_LOAD);
  assign in_fire = s_tvalid && s_tready;
  assign in_ok = (in_sample.depth >= min_depth) && (in_sample.depth <= max_depth);
  assign wr_en = in_fire && in_ok && (count < CW'(MAX_SAMPLES));

  mdbp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count[AW-1:0]), .wr_data(in_sample),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_raw)
  );

  mdbp_select #(.MAX_SAMPLES(MAX_SAMPLES)) u_sel (
    .clk(clk), .rst(rst), .start(sel_start), .n(count),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(sample_t'(rd_raw)),
    .done(sel_done), .result(sel_res)
  );

  // Pixel offset from the principal point in 1/16 pixel, then times depth.
  always_comb begin
    if (state == ST_MULX) begin
      diff = $signed({2'b00, pick.column, 4'b0000}) - $signed({2'b00, center_x});
    end else begin
      diff = $signed({2'b00, pick.row, 4'b0000}) - $signed({2'b00, center_y});
    end
  end

  assign div_start = (state == ST_DIVX || state == ST_DIVY) && !div_wait;

  mdbp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod),
    .den((state == ST_DIVX) ? focal_x : focal_y),
    .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= 16'd100;
      max_depth <= 16'd10000;
      focal_x <= 16'd8192;
      focal_y <= 16'd8192;
      center_x <= 16'd5120;
      center_y <= 16'd3840;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_DEPTH: min_depth <= cfg_data;
        REG_MAX_DEPTH: max_depth <= cfg_data;
        REG_FOCAL_X:   focal_x <= cfg_data;
        REG_FOCAL_Y:   focal_y <= cfg_data;
        REG_CENTER_X:  center_x <= cfg_data;
        REG_CENTER_Y:  center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      overflow_seen <= 1'b0;
      sel_start <= 1'b0;
      div_wait <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      sel_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        ST_LOAD: begin
          if (in_fire) begin
            if (wr_en) begin
              count <= count + CW'(1);
            end else if (in_ok) begin
              overflow_seen <= 1'b1;
            end
            if (s_tlast) begin
              found <= (count != '0) || wr_en;
              if ((count != '0) || wr_en) begin
                sel_start <= 1'b1;
                state <= ST_SEL;
              end else begin
                pick <= '0;
                x_mm <= '0;
                prod <= '0;
                state <= ST_FIN;
              end
            end
          end
        end
        ST_SEL: begin
          if (sel_done) begin
            pick <= sel_res;
            state <= ST_MULX;
          end
        end
        ST_MULX, ST_MULY: begin
          prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, pick.depth}));
          div_wait <= 1'b0;
          state <= (state == ST_MULX) ? ST_DIVX : ST_DIVY;
        end
        ST_DIVX, ST_DIVY: begin
          div_wait <= 1'b1;
          if (div_done) begin
            if (state == ST_DIVX) begin
              x_mm <= div_q;
              state <= ST_MULY;
            end else begin
              prod <= PROD_W'(div_q);
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          // The y quotient is parked in prod until the output register frees.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0, overflow_seen, prod[COORD_W-1:0], x_mm,
                        pick.row, pick.column, pick.depth, found};
            count <= '0;
            overflow_seen <= 1'b0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// File: rtl/core/mdbp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data; no package dependency.
module mdbp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/mdbp_select.sv
// Median selector: radix selection over the sample RAM, one bit of depth per pass,
// then one pass that picks the tied sample by arrival. Uses mdbp_pkg.
module mdbp_select #(
  parameter int MAX_SAMPLES = mdbp_pkg::MAX_SAMPLES_DEF,
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CW-1:0]     n,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  mdbp_pkg::sample_t rd_data,
  output logic              done,
  output mdbp_pkg::sample_t result
);
  import mdbp_pkg::*;

  logic busy;
  logic [4:0] pass;
  logic [DEPTH_W-1:0] prefix;
  logic [CW-1:0] krem;
  logic [CW-1:0] cnt;
  logic [AW-1:0] addr;
  logic issuing;
  logic rvalid;
  logic rlast;

  logic [3:0] bidx;
  logic [DEPTH_W-1:0] mask;
  logic last_addr;
  logic match;
  logic [CW-1:0] cnt_tot;

  assign bidx = 4'd15 - pass[3:0];
  // Bits above the one under test are already settled in prefix.
  assign mask = {DEPTH_W{1'b1}} << ({1'b0, bidx} + 5'd1);
  assign last_addr = ((CW'(addr) + CW'(1)) == n);
  assign match = (((rd_data.depth ^ prefix) & mask) == '0) && !rd_data.depth[bidx];
  assign cnt_tot = cnt + (match ? CW'(1) : CW'(0));
  assign rd_en = issuing;
  assign rd_addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      issuing <= 1'b0;
      rvalid <= 1'b0;
      rlast <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      rvalid <= issuing;
      rlast <= issuing && last_addr;
      if (start) begin
        busy <= 1'b1;
        pass <= 5'd0;
        prefix <= '0;
        krem <= n >> 1;
        cnt <= '0;
        addr <= '0;
        issuing <= 1'b1;
      end else if (busy) begin
        if (issuing) begin
          addr <= addr + AW'(1);
          if (last_addr) begin
            issuing <= 1'b0;
          end
        end
        if (rvalid) begin
          if (!pass[4]) begin
            cnt <= cnt_tot;
            if (rlast) begin
              if (krem < cnt_tot) begin
                prefix[bidx] <= 1'b0;
              end else begin
                prefix[bidx] <= 1'b1;
                krem <= krem - cnt_tot;
              end
              pass <= pass + 5'd1;
              cnt <= '0;
              addr <= '0;
              issuing <= 1'b1;
            end
          end else if (rd_data.depth == prefix) begin
            if (cnt == krem) begin
              result <= rd_data;
              done <= 1'b1;
              busy <= 1'b0;
              issuing <= 1'b0;
              rvalid <= 1'b0;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/mdbp_div.sv
// Signed-by-unsigned restoring divider, one quotient bit per cycle, truncating
// toward zero with saturation to signed 32 bits. Uses mdbp_pkg.
module mdbp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [mdbp_pkg::PROD_W-1:0] num,
  input  logic [mdbp_pkg::CFG_W-1:0]         den,
  output logic                               done,
  output logic signed [mdbp_pkg::COORD_W-1:0] quo
);
  import mdbp_pkg::*;

  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic busy;
  logic neg;
  logic [CFG_W-1:0] divisor;
  logic [PROD_W-1:0] mag;
  logic [CFG_W-1:0] rem;
  logic [PROD_W-1:0] acc;
  logic [5:0] cnt;
  logic [CFG_W:0] rem_sh;
  logic take;

  assign rem_sh = {rem, mag[PROD_W-1]};
  assign take = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[PROD_W-1];
        divisor <= den;
        mag <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
        rem <= '0;
        acc <= '0;
        cnt <= '0;
        if (den == '0) begin
          done <= 1'b1;
          if (num == '0) begin
            quo <= '0;
          end else begin
            quo <= num[PROD_W-1] ? SAT_MIN : SAT_MAX;
          end
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == 6'(PROD_W)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            quo <= (acc > PROD_W'(SAT_MIN)) ? SAT_MIN : COORD_W'(-acc);
          end else begin
            quo <= (acc > PROD_W'(SAT_MAX)) ? SAT_MAX : acc[COORD_W-1:0];
          end
        end else begin
          rem <= take ? CFG_W'(rem_sh - {1'b0, divisor}) : rem_sh[CFG_W-1:0];
          acc <= {acc[PROD_W-2:0], take};
          mag <= mag << 1;
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

endmodule

// File: rtl/core/mdbp_checker.sv
// Port-level checker for the median depth back-projector, bound to the top level.
// Depends on mdbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mdbp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [mdbp_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import mdbp_pkg::*;

  // A stalled result word stays offered and unchanged.
  `MDBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `MDBP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  // Closing a region stops input while the median is worked out.
  `MDBP_ASSERT_NEXT(a_last_stalls, s_tvalid && s_tready && s_tlast, !s_tready)
  // An empty region reports nothing but its overflow flag.
  `MDBP_ASSERT_IMPL(a_empty_zero, m_tvalid && !m_tdata[0], m_tdata[104:1] == '0)

endmodule

bind median_depth_backprojector_core mdbp_checker u_mdbp_checker (.*);
